### rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants and types for the semiprime factor finder.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Default width of the tested number
  localparam int NUM_WIDTH_DEF = 16;

  // Smallest semiprime (2*2); anything below it is rejected at once
  localparam int SMALLEST_SEMIPRIME = 4;

  // First trial divisor and its square
  localparam int FIRST_DIVISOR = 2;
  localparam int FIRST_DIVISOR_SQ = FIRST_DIVISOR * FIRST_DIVISOR;

  // Status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } spf_div_sts_t;

endpackage

### rtl/spf_if.sv
// ----------------------------------------------------------------------------
// spf_if
// Valid/ready channels for the number word and the factor result word.
// ----------------------------------------------------------------------------
interface spf_num_if #(
  parameter int W = spf_pkg::NUM_WIDTH_DEF
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface spf_res_if #(
  parameter int W = spf_pkg::NUM_WIDTH_DEF
) ();
  logic         valid;
  logic         ready;
  logic         is_semiprime;
  logic [W-1:0] small_factor;
  logic [W-1:0] large_factor;

  modport source (output valid, output is_semiprime, output small_factor,
                  output large_factor, input ready);
  modport sink   (input valid, input is_semiprime, input small_factor,
                  input large_factor, output ready);
endinterface

### rtl/spf_divider.sv
// ----------------------------------------------------------------------------
// spf_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spf_divider #(
  parameter int W = spf_pkg::NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  output spf_pkg::spf_div_sts_t sts,
  output logic [W-1:0]         quotient,
  output logic [W-1:0]         remainder
);

  localparam int CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [W-1:0]    quo_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    dsr_r;

  logic [W:0]      shifted;
  logic [W:0]      diff;

  // Trial subtract of the shifted partial remainder
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  // Step count and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= CntW'(W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/semiprime_factor_finder_core.sv
// ----------------------------------------------------------------------------
// semiprime_factor_finder_core
// Trial-division test for numbers that are a product of exactly two primes.
// ----------------------------------------------------------------------------
// Each number word is tested by trial division with one shared bit-serial
// divider. Divisors d = 2, 3, ... are tried while d*d <= n to find the smallest
// prime factor p; the cofactor q = n/p then gets the same treatment starting at
// d = p to check that it is prime. Each trial divisor takes a compare of d*d
// with the value, the NUM_WIDTH divider steps and a step that acts on the
// remainder; numbers below 4 are rejected without a division. The input is not
// ready while a number is being worked on; the finished result sits in an
// output register, so the next number is taken while it waits to be read.
// ----------------------------------------------------------------------------
module semiprime_factor_finder_core #(
  parameter int NUM_WIDTH = spf_pkg::NUM_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  spf_num_if.sink  in_chan,
  spf_res_if.source out_chan
);

  localparam int SqW = NUM_WIDTH + 2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic                  phase_r, phase_nxt;   // 0: find p in n, 1: test q
  logic [NUM_WIDTH-1:0]  val_r, val_nxt;       // value under test
  logic [NUM_WIDTH-1:0]  dvs_r, dvs_nxt;       // trial divisor
  logic [SqW-1:0]        sq_r, sq_nxt;         // trial divisor squared
  logic [NUM_WIDTH-1:0]  p_r, p_nxt;
  logic                  res_flag_r, res_flag_nxt;
  logic [NUM_WIDTH-1:0]  res_small_r, res_small_nxt;
  logic [NUM_WIDTH-1:0]  res_large_r, res_large_nxt;

  logic                  out_valid_r;
  logic                  out_flag_r;
  logic [NUM_WIDTH-1:0]  out_small_r;
  logic [NUM_WIDTH-1:0]  out_large_r;

  logic                  div_start;
  spf_pkg::spf_div_sts_t div_sts;
  logic [NUM_WIDTH-1:0]  div_quo;
  logic [NUM_WIDTH-1:0]  div_rem;
  logic                  out_free;

  spf_divider #(.W(NUM_WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (val_r),
    .divisor   (dvs_r),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  // Sequencer: compare d*d with the value, divide, act on the remainder
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    val_nxt       = val_r;
    dvs_nxt       = dvs_r;
    sq_nxt        = sq_r;
    p_nxt         = p_r;
    res_flag_nxt  = res_flag_r;
    res_small_nxt = res_small_r;
    res_large_nxt = res_large_r;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          val_nxt       = in_chan.number;
          dvs_nxt       = NUM_WIDTH'(spf_pkg::FIRST_DIVISOR);
          sq_nxt        = SqW'(spf_pkg::FIRST_DIVISOR_SQ);
          phase_nxt     = 1'b0;
          res_flag_nxt  = 1'b0;
          res_small_nxt = '0;
          res_large_nxt = '0;
          if (in_chan.number < NUM_WIDTH'(spf_pkg::SMALLEST_SEMIPRIME)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > {2'b00, val_r}) begin
          // No divisor up to the square root: the value is prime
          if (phase_r) begin
            res_flag_nxt  = 1'b1;
            res_small_nxt = p_r;
            res_large_nxt = val_r;
          end
          state_nxt = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_sts.done) begin
          if (div_rem == '0) begin
            if (!phase_r) begin
              // Smallest factor found; go on to test the cofactor from p up
              p_nxt     = dvs_r;
              val_nxt   = div_quo;
              phase_nxt = 1'b1;
              state_nxt = ST_CHECK;
            end else begin
              // Cofactor is composite
              state_nxt = ST_EMIT;
            end
          end else begin
            dvs_nxt   = dvs_r + 1'b1;
            sq_nxt    = sq_r + {1'b0, dvs_r, 1'b1};
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Working values
  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    dvs_r       <= dvs_nxt;
    sq_r        <= sq_nxt;
    p_r         <= p_nxt;
    res_flag_r  <= res_flag_nxt;
    res_small_r <= res_small_nxt;
    res_large_r <= res_large_nxt;
  end

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_flag_r  <= res_flag_r;
      out_small_r <= res_small_r;
      out_large_r <= res_large_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_semiprime = out_flag_r;
  assign out_chan.small_factor = out_small_r;
  assign out_chan.large_factor = out_large_r;

endmodule

### rtl/spf_checker.sv
// ----------------------------------------------------------------------------
// spf_checker
// Port-level checks for the semiprime factor finder, bound to the top level.
// ----------------------------------------------------------------------------
module spf_checker #(
  parameter int W = spf_pkg::NUM_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic         out_is_semiprime,
  input logic [W-1:0] out_small_factor,
  input logic [W-1:0] out_large_factor
);

  // Not ready in the cycle after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a word was accepted");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_is_semiprime)
      && $stable(out_small_factor) && $stable(out_large_factor)))
    else $error("result word changed while stalled");

  // Non-semiprime results carry zero factors
  a_zero_factors: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_semiprime) |->
      (out_small_factor == '0 && out_large_factor == '0))
    else $error("nonzero factors on a non-semiprime result");

  // Semiprime results are ordered and nontrivial
  a_factor_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_semiprime) |->
      (out_small_factor > W'(1) && out_small_factor <= out_large_factor))
    else $error("factors out of order on a semiprime result");

  // Nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind semiprime_factor_finder_core spf_checker #(.W(NUM_WIDTH)) u_spf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_is_semiprime (out_chan.is_semiprime),
  .out_small_factor (out_chan.small_factor),
  .out_large_factor (out_chan.large_factor)
);
